### src/lbo_pkg.sv
// Package for the line break opportunity check.
// Holds code point constants and the punctuation/whitespace class functions.
// No dependencies.
package lbo_pkg;

    localparam int unsigned CodeWidth = 32;

    typedef logic [CodeWidth-1:0] code_t;

    localparam code_t CODE_NONE       = 32'h0000_0000;
    localparam code_t CODE_SENTINEL   = 32'hFFFF_FFFF;
    localparam code_t CODE_HYPHEN     = 32'h0000_002D;
    localparam code_t CODE_SEMICOLON  = 32'h0000_003B;
    localparam code_t CODE_SLASH      = 32'h0000_002F;
    localparam code_t CODE_BAR        = 32'h0000_007C;
    localparam code_t CODE_TAB        = 32'h0000_0009;
    localparam code_t CODE_CR         = 32'h0000_000D;
    localparam code_t CODE_SPACE      = 32'h0000_0020;
    localparam code_t CODE_IDEO_STOP  = 32'h0000_3002;
    localparam code_t CODE_FW_COMMA   = 32'h0000_FF0C;
    localparam code_t HANGUL_JAMO_LO  = 32'h0000_1100;
    localparam code_t HANGUL_JAMO_HI  = 32'h0000_11FF;
    localparam code_t CJK_LO          = 32'h0000_3000;
    localparam code_t CJK_HI          = 32'h0000_D7AF;
    localparam code_t CJK_COMPAT_LO   = 32'h0000_F900;
    localparam code_t CJK_COMPAT_HI   = 32'h0000_FAFF;
    localparam code_t FULLWIDTH_LO    = 32'h0000_FF00;
    localparam code_t HALFWIDTH_LO    = 32'h0000_FFA0;
    localparam code_t HALFWIDTH_SPAN  = 32'h0000_003C;
    localparam code_t HALFWIDTH_HI    = HALFWIDTH_LO + HALFWIDTH_SPAN;

    function automatic logic is_space(input code_t code);
        return ((code >= CODE_TAB) && (code <= CODE_CR)) || (code == CODE_SPACE);
    endfunction

    function automatic logic is_opening(input code_t code);
        logic hit;
        case (code)
            32'h24, 32'h28, 32'h5B, 32'h5C, 32'h7B,
            32'h2018, 32'h201C, 32'h2035,
            32'h3008, 32'h300A, 32'h300C, 32'h300E, 32'h3010, 32'h3014, 32'h301D,
            32'hFE59, 32'hFE5B, 32'hFE5D,
            32'hFF04, 32'hFF08, 32'hFF3B, 32'hFF5B, 32'hFFE1, 32'hFFE5,
            32'hFFE6: hit = 1'b1;
            default:  hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic is_closing(input code_t code);
        logic hit;
        case (code)
            32'h21, 32'h25, 32'h29, 32'h2C, 32'h2E, 32'h3A, 32'h3B, 32'h3F,
            32'h5D, 32'h7D, 32'hB0, 32'hB7,
            32'h2013, 32'h2014, 32'h2019, 32'h201D, 32'h2022, 32'h2026, 32'h2027,
            32'h2032, 32'h2033, 32'h2103,
            32'h3001, 32'h3002, 32'h3009, 32'h300B, 32'h300D, 32'h300F,
            32'h3011, 32'h3015, 32'h301E, 32'h30FC,
            32'hFE30, 32'hFE50, 32'hFE51, 32'hFE52, 32'hFE54, 32'hFE55,
            32'hFE56, 32'hFE57, 32'hFE5A, 32'hFE5C, 32'hFE5E,
            32'hFF01, 32'hFF05, 32'hFF09, 32'hFF0C, 32'hFF0E, 32'hFF1A,
            32'hFF1B, 32'hFF1F, 32'hFF3D, 32'hFF5D, 32'hFF70, 32'hFF9E,
            32'hFF9F, 32'hFFE0: hit = 1'b1;
            default:            hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic in_range(input code_t code, input code_t lo, input code_t hi);
        return (code >= lo) && (code <= hi);
    endfunction

endpackage

### src/lbo_classify.sv
// Combinational break decision for one pair of code points.
// Depends on lbo_pkg for constants and class functions.
module lbo_classify (
    input  lbo_pkg::code_t current_code,
    input  lbo_pkg::code_t previous_code,
    output logic           may_break
);

    logic prev_friendly;
    logic cur_friendly;
    logic ideographic;

    assign prev_friendly = (previous_code == lbo_pkg::CODE_HYPHEN)
                        || (previous_code == lbo_pkg::CODE_SEMICOLON)
                        || (previous_code == lbo_pkg::CODE_SLASH);

    assign cur_friendly = (current_code == lbo_pkg::CODE_BAR)
                       || (current_code == lbo_pkg::CODE_SENTINEL);

    assign ideographic = (previous_code == lbo_pkg::CODE_IDEO_STOP)
        || (previous_code == lbo_pkg::CODE_FW_COMMA)
        || lbo_pkg::in_range(current_code, lbo_pkg::HANGUL_JAMO_LO, lbo_pkg::HANGUL_JAMO_HI)
        || lbo_pkg::in_range(current_code, lbo_pkg::CJK_LO, lbo_pkg::CJK_HI)
        || lbo_pkg::in_range(current_code, lbo_pkg::CJK_COMPAT_LO, lbo_pkg::CJK_COMPAT_HI)
        || lbo_pkg::in_range(current_code, lbo_pkg::FULLWIDTH_LO, lbo_pkg::HALFWIDTH_HI);

    // First matching rule decides
    always_comb
    begin
        if (previous_code == lbo_pkg::CODE_NONE)
        begin
            may_break = 1'b0;
        end
        else if (prev_friendly || cur_friendly)
        begin
            may_break = 1'b1;
        end
        else if (lbo_pkg::is_space(previous_code))
        begin
            may_break = 1'b0;
        end
        else if (lbo_pkg::is_space(current_code))
        begin
            may_break = 1'b1;
        end
        else if (lbo_pkg::is_opening(previous_code) || lbo_pkg::is_closing(current_code))
        begin
            may_break = 1'b0;
        end
        else
        begin
            may_break = ideographic;
        end
    end

endmodule

### src/line_break_opportunity_check.sv
// Top level of the line break opportunity check.
// Registers the input pair and the decision; depends on lbo_pkg and lbo_classify.
//
// Usage:
//   Raise start with a pair of code points on current_code and previous_code.
//   The word is taken at the clock edge where start is high and busy is low.
//   busy is always low: a new word can be taken in every cycle.
//   The decision passes the input register, then the result register, and
//   appears on may_break, marked by done for exactly one cycle; one result
//   per word, in order.
//   Throughput: 1 word per cycle, set by the single classify pass between
//   the input register and the result register.
//   The receiver cannot stall: it must take each result while done is high.
//   Reset (rst_n low, asynchronous) clears the valid flags of both stages;
//   words in flight are dropped and done stays low until new words arrive.
//   previous_code of zero means no previous character (no break);
//   current_code of all ones is an end sentinel (break).
module line_break_opportunity_check (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  lbo_pkg::code_t current_code,
    input  lbo_pkg::code_t previous_code,
    output logic           done,
    output logic           may_break
);

    logic           in_valid_reg;
    logic           in_valid_next;
    lbo_pkg::code_t cur_reg;
    lbo_pkg::code_t prev_reg;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic           brk_reg;
    logic           brk_next;
    logic           accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign in_valid_next  = accept;
    assign out_valid_next = in_valid_reg;

    lbo_classify u_classify (
        .current_code  (cur_reg),
        .previous_code (prev_reg),
        .may_break     (brk_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload when idle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_reg  <= current_code;
            prev_reg <= previous_code;
        end
        if (in_valid_reg)
        begin
            brk_reg <= brk_next;
        end
    end

    assign done      = out_valid_reg;
    assign may_break = brk_reg;

endmodule
